>>> hw/rtl/pdcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power diagram cell locator: shared types and constants
// Operation and status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package pdcl_pkg;

   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;
   localparam int INDEX_BITS  = 8;
   localparam int WEIGHT_BITS = 48;
   localparam int DIST_BITS   = 51;

   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_MULX,
      S_MULY,
      S_CMP
   } state_type;

endpackage

>>> hw/rtl/power_diagram_cell_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power diagram cell locator
// Site table of weighted circles with a point query that returns the site of
// least power distance, ties to the lowest index, using one shared squarer.
//
//   channel  ports                          handshake
//   request  req_* (operation, x, y, r^2)   start high, busy low
//   result   rsp_* (index, distance, stat)  rsp_valid strobe, one cycle
//
// Append, clear, an unused code and a query on an empty table: the result
// appears in the cycle after acceptance and busy stays low.
// Query over N stored sites: busy from acceptance on, result in the first cycle
// with busy low again; per site the squarer takes dx^2, then dy^2, then the
// key is compared, with one table read per site.
// Reset clears the site count, the state and the result strobe; the table needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module power_diagram_cell_locator #(
   parameter int MAX_SITES  = 256,
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [pdcl_pkg::OP_BITS-1:0]          req_operation,
   input  logic signed [COORD_BITS-1:0]          req_x_coord,
   input  logic signed [COORD_BITS-1:0]          req_y_coord,
   input  logic [pdcl_pkg::WEIGHT_BITS-1:0]      req_squared_radius,
   output logic                                  rsp_valid,
   output logic [pdcl_pkg::INDEX_BITS-1:0]       rsp_cell_index,
   output logic signed [pdcl_pkg::DIST_BITS-1:0] rsp_power_distance,
   output logic [pdcl_pkg::STATUS_BITS-1:0]      rsp_status
);

   import pdcl_pkg::*;

   localparam int COUNT_BITS = $clog2(MAX_SITES + 1);
   localparam int IDX_BITS   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int SQ_BITS    = 2 * COORD_BITS + 2;
   localparam int EXT_BITS   = (SQ_BITS > DIST_BITS) ? SQ_BITS : DIST_BITS;
   localparam int ENTRY_BITS = 2 * COORD_BITS + WEIGHT_BITS;
   localparam logic [EXT_BITS-1:0] WEIGHT_BIAS = EXT_BITS'(1) << WEIGHT_BITS;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [ENTRY_BITS-1:0] site_mem [MAX_SITES];
   logic [ENTRY_BITS-1:0] rd_ff;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   logic [COUNT_BITS-1:0]        idx_ff;
   logic [SQ_BITS-1:0]           prod_ff;
   logic [EXT_BITS-1:0]          acc_ff;
   logic [EXT_BITS-1:0]          best_key_ff;
   logic [IDX_BITS-1:0]          best_ff;

   logic [INDEX_BITS-1:0] rsp_index_ff;
   logic [DIST_BITS-1:0]  rsp_dist_ff;
   status_type            rsp_status_ff;

   op_type                op;
   logic                  accept;
   logic                  full;
   logic                  go_query;
   logic                  imm_rsp;
   status_type            imm_status;
   logic                  append_ok;
   logic                  clear_req;
   logic [COUNT_BITS-1:0] idx_next;
   logic                  last;
   logic                  done_q;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  sel_y;

   logic signed [COORD_BITS-1:0] site_x, site_y, q_sel, s_sel;
   logic [WEIGHT_BITS-1:0]       site_w;
   logic signed [COORD_BITS:0]   diff;
   logic [COORD_BITS:0]          mag;
   logic [SQ_BITS-1:0]           sq;
   logic [EXT_BITS-1:0]          key;
   logic                         better;
   logic [EXT_BITS-1:0]          win_key;
   logic [IDX_BITS-1:0]          win_idx;
   logic [EXT_BITS-1:0]          win_dist;
   logic [IDX_BITS+INDEX_BITS-1:0] win_idx_ext;

   // request decode
   always_comb begin
      op         = op_type'(req_operation);
      accept     = start && !busy;
      full       = (count_ff == COUNT_BITS'(MAX_SITES));
      go_query   = accept && (op == OP_QUERY) && (count_ff != '0);
      imm_rsp    = accept && !go_query;
      append_ok  = accept && (op == OP_APPEND) && !full;
      clear_req  = accept && (op == OP_CLEAR);
      idx_next   = idx_ff + COUNT_BITS'(1);
      last       = (idx_next == count_ff);
      done_q     = (state_ff == S_CMP) && last;
      unique case (op)
         OP_APPEND: imm_status = full ? ST_FULL : ST_DONE;
         OP_QUERY:  imm_status = ST_EMPTY;
         default:   imm_status = ST_DONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (go_query) state_in = S_FETCH;
         S_FETCH: state_in = S_MULX;
         S_MULX:  state_in = S_MULY;
         S_MULY:  state_in = S_CMP;
         S_CMP:   state_in = last ? S_IDLE : S_MULX;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy    = 1'b1;
      rd_en   = 1'b0;
      rd_addr = idx_ff[IDX_BITS-1:0];
      sel_y   = 1'b0;
      unique case (state_ff)
         S_IDLE:  busy = 1'b0;
         S_FETCH: rd_en = 1'b1;
         S_MULX:  sel_y = 1'b0;
         S_MULY:  sel_y = 1'b1;
         S_CMP: begin
            rd_en   = !last;
            rd_addr = idx_next[IDX_BITS-1:0];
         end
         default: busy = 1'b1;
      endcase
   end

   // shared squarer and key compare
   always_comb begin
      site_x   = rd_ff[ENTRY_BITS-1 -: COORD_BITS];
      site_y   = rd_ff[WEIGHT_BITS +: COORD_BITS];
      site_w   = rd_ff[WEIGHT_BITS-1:0];
      q_sel    = sel_y ? qy_ff : qx_ff;
      s_sel    = sel_y ? site_y : site_x;
      diff     = {q_sel[COORD_BITS-1], q_sel} - {s_sel[COORD_BITS-1], s_sel};
      mag      = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
      sq       = SQ_BITS'(mag) * SQ_BITS'(mag);
      key      = acc_ff + EXT_BITS'(prod_ff);
      better   = (idx_ff == '0) || (key < best_key_ff);
      win_key  = better ? key : best_key_ff;
      win_idx  = better ? idx_ff[IDX_BITS-1:0] : best_ff;
      win_dist = win_key - WEIGHT_BIAS;
      win_idx_ext = {{INDEX_BITS{1'b0}}, win_idx};
   end

   // control registers
   always_comb begin
      count_in = count_ff;
      if (clear_req) begin
         count_in = '0;
      end else if (append_ok) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
      rsp_valid_in = imm_rsp || done_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // site table
   always_ff @(posedge clock) begin
      if (append_ok) begin
         site_mem[count_ff[IDX_BITS-1:0]] <=
            {req_x_coord, req_y_coord, req_squared_radius};
      end
      if (rd_en) begin
         rd_ff <= site_mem[rd_addr];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (go_query) begin
         qx_ff  <= req_x_coord;
         qy_ff  <= req_y_coord;
         idx_ff <= '0;
      end
      if (state_ff == S_MULX || state_ff == S_MULY) begin
         prod_ff <= sq;
      end
      if (state_ff == S_MULY) begin
         acc_ff <= EXT_BITS'(prod_ff) + WEIGHT_BIAS - EXT_BITS'(site_w);
      end
      if (state_ff == S_CMP) begin
         best_key_ff <= win_key;
         best_ff     <= win_idx;
         idx_ff      <= idx_next;
      end
      if (imm_rsp) begin
         rsp_index_ff  <= '0;
         rsp_dist_ff   <= '0;
         rsp_status_ff <= imm_status;
      end else if (done_q) begin
         rsp_index_ff  <= win_idx_ext[INDEX_BITS-1:0];
         rsp_dist_ff   <= win_dist[DIST_BITS-1:0];
         rsp_status_ff <= ST_DONE;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_index     = rsp_index_ff;
   assign rsp_power_distance = $signed(rsp_dist_ff);
   assign rsp_status         = rsp_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_SITES))
      else $error("site count above table depth");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (count_ff != '0))
      else $error("scan running over empty table");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_imm_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation != OP_QUERY)) |=> rsp_valid)
      else $error("missing result for non-query transaction");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |->
         (rsp_cell_index == '0 && rsp_power_distance == '0))
      else $error("error result with non-zero fields");

endmodule
